### rtl/tkse_pkg.sv
package tkse_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned SEQ_MAX    = 8;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_APP_CURSOR   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NEWLINE      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ALT_IS_META  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BKSP_DEL     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_META_RESERVE = 3'd4;

    typedef struct packed {
        logic app_cursor_mode;
        logic newline_mode;
        logic alt_is_meta;
        logic backspace_sends_del;
        logic meta_alone_reserved;
    } cfg_t;

    // one encoded key sequence, bytes[0] goes out first
    typedef struct packed {
        logic [3:0]                len;
        logic [SEQ_MAX-1:0][7:0]   bytes;
    } seq_t;

    // queue entry handed from the front end to the queue
    typedef struct packed {
        logic push;
        seq_t seq;
    } push_t;

endpackage

### rtl/tkse_front.sv
module tkse_front (
    input  tkse_pkg::cfg_t  cfg,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [31:0]     s_tdata,
    input  logic            s_tuser,
    input  logic            queue_full,
    output tkse_pkg::push_t push_out
);

    localparam logic [5:0] KEY_CUR_UP      = 6'd1;
    localparam logic [5:0] KEY_CUR_DOWN    = 6'd2;
    localparam logic [5:0] KEY_CUR_RIGHT   = 6'd3;
    localparam logic [5:0] KEY_CUR_LEFT    = 6'd4;
    localparam logic [5:0] KEY_CUR_HOME    = 6'd5;
    localparam logic [5:0] KEY_CUR_END     = 6'd6;
    localparam logic [5:0] KEY_INS         = 6'd7;
    localparam logic [5:0] KEY_DEL         = 6'd8;
    localparam logic [5:0] KEY_PGUP        = 6'd9;
    localparam logic [5:0] KEY_PGDN        = 6'd10;
    localparam logic [5:0] KEY_F1          = 6'd11;
    localparam logic [5:0] KEY_F2          = 6'd12;
    localparam logic [5:0] KEY_F3          = 6'd13;
    localparam logic [5:0] KEY_F4          = 6'd14;
    localparam logic [5:0] KEY_F5          = 6'd15;
    localparam logic [5:0] KEY_F6          = 6'd16;
    localparam logic [5:0] KEY_F7          = 6'd17;
    localparam logic [5:0] KEY_F8          = 6'd18;
    localparam logic [5:0] KEY_F9          = 6'd19;
    localparam logic [5:0] KEY_F10         = 6'd20;
    localparam logic [5:0] KEY_F11         = 6'd21;
    localparam logic [5:0] KEY_F12         = 6'd22;
    localparam logic [5:0] KEY_RETURN      = 6'd23;
    localparam logic [5:0] KEY_BKSP        = 6'd24;
    localparam logic [5:0] KEY_TAB         = 6'd25;
    localparam logic [5:0] KEY_SHIFT_TAB   = 6'd26;
    localparam logic [5:0] KEY_ESC         = 6'd27;
    localparam logic [5:0] KEY_MODIFIER    = 6'd28;
    localparam logic [5:0] KEY_A           = 6'd29;
    localparam logic [5:0] KEY_Z           = 6'd54;
    localparam logic [5:0] KEY_P_SPACE     = 6'd55;
    localparam logic [5:0] KEY_P_LBRACKET  = 6'd56;
    localparam logic [5:0] KEY_P_BSLASH    = 6'd57;
    localparam logic [5:0] KEY_P_RBRACKET  = 6'd58;
    localparam logic [5:0] KEY_P_CARET     = 6'd59;
    localparam logic [5:0] KEY_P_USCORE    = 6'd60;
    localparam logic [5:0] KEY_P_QUESTION  = 6'd61;

    localparam logic [7:0] ESC_B   = 8'h1B;
    localparam logic [7:0] CSI_B   = 8'h5B;
    localparam logic [7:0] SS3_B   = 8'h4F;
    localparam logic [7:0] SEMI_B  = 8'h3B;
    localparam logic [7:0] ONE_B   = 8'h31;
    localparam logic [7:0] TILDE_B = 8'h7E;
    localparam logic [7:0] DEL_B   = 8'h7F;
    localparam logic [7:0] BS_B    = 8'h08;

    function automatic tkse_pkg::seq_t put(tkse_pkg::seq_t s, logic [7:0] v);
        tkse_pkg::seq_t r;
        r = s;
        r.bytes[s.len[2:0]] = v;
        r.len = s.len + 4'd1;
        return r;
    endfunction

    // decimal of a value below 30, tens digit only when ten or more
    function automatic tkse_pkg::seq_t put_dec(tkse_pkg::seq_t s, logic [4:0] v);
        tkse_pkg::seq_t r;
        logic [4:0]     ones;
        r = s;
        ones = v;
        if (v >= 5'd20) begin
            r = put(r, 8'h32);
            ones = v - 5'd20;
        end else if (v >= 5'd10) begin
            r = put(r, 8'h31);
            ones = v - 5'd10;
        end
        r = put(r, 8'h30 + {4'd0, ones[3:0]});
        return r;
    endfunction

    function automatic logic [7:0] cursor_final(logic [5:0] k);
        logic [7:0] f;
        unique case (k)
            KEY_CUR_UP:    f = 8'h41;
            KEY_CUR_DOWN:  f = 8'h42;
            KEY_CUR_RIGHT: f = 8'h43;
            KEY_CUR_LEFT:  f = 8'h44;
            KEY_CUR_HOME:  f = 8'h48;
            KEY_CUR_END:   f = 8'h46;
            KEY_F1:        f = 8'h50;
            KEY_F2:        f = 8'h51;
            KEY_F3:        f = 8'h52;
            KEY_F4:        f = 8'h53;
            default:       f = 8'h41;
        endcase
        return f;
    endfunction

    function automatic logic [4:0] tilde_num(logic [5:0] k);
        logic [4:0] n;
        unique case (k)
            KEY_INS:  n = 5'd2;
            KEY_DEL:  n = 5'd3;
            KEY_PGUP: n = 5'd5;
            KEY_PGDN: n = 5'd6;
            KEY_F5:   n = 5'd15;
            KEY_F6:   n = 5'd17;
            KEY_F7:   n = 5'd18;
            KEY_F8:   n = 5'd19;
            KEY_F9:   n = 5'd20;
            KEY_F10:  n = 5'd21;
            KEY_F11:  n = 5'd23;
            KEY_F12:  n = 5'd24;
            default:  n = 5'd2;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] ctrl_punct(logic [5:0] k);
        logic [7:0] c;
        unique case (k)
            KEY_P_SPACE:    c = 8'h00;
            KEY_P_LBRACKET: c = 8'h1B;
            KEY_P_BSLASH:   c = 8'h1C;
            KEY_P_RBRACKET: c = 8'h1D;
            KEY_P_CARET:    c = 8'h1E;
            KEY_P_USCORE:   c = 8'h1F;
            KEY_P_QUESTION: c = 8'h7F;
            default:        c = 8'h00;
        endcase
        return c;
    endfunction

    logic [5:0]     key_raw;
    logic [5:0]     key;
    logic [3:0]     mask;
    logic [20:0]    cp_raw;
    logic [20:0]    cp;
    logic           alt;
    logic           ctrl;
    logic           meta;
    logic           esc_prefix;
    logic [4:0]     mod_num;
    logic           dropped;
    tkse_pkg::seq_t seq;

    assign key_raw = s_tdata[5:0];
    assign mask    = s_tdata[9:6];
    assign cp_raw  = s_tdata[30:10];

    always_comb begin
        alt        = mask[1];
        ctrl       = mask[2];
        meta       = mask[3];
        esc_prefix = alt & cfg.alt_is_meta;
        mod_num    = (mask == 4'd0) ? 5'd0 : {1'b0, mask} + 5'd1;
        dropped    = cfg.meta_alone_reserved & meta & ~ctrl & ~alt;
        key        = (key_raw > KEY_P_QUESTION) ? 6'd0 : key_raw;
        // surrogates and values past the unicode range become the replacement char
        if (cp_raw > 21'h10FFFF || (cp_raw >= 21'h00D800 && cp_raw <= 21'h00DFFF)) begin
            cp = 21'h00FFFD;
        end else begin
            cp = cp_raw;
        end

        seq = '0;
        unique case (key) inside
            [KEY_CUR_UP:KEY_CUR_END], [KEY_F1:KEY_F4]: begin
                seq = put(seq, ESC_B);
                if (mod_num != 5'd0) begin
                    seq = put(seq, CSI_B);
                    seq = put(seq, ONE_B);
                    seq = put(seq, SEMI_B);
                    seq = put_dec(seq, mod_num);
                end else if (cfg.app_cursor_mode || key >= KEY_F1) begin
                    seq = put(seq, SS3_B);
                end else begin
                    seq = put(seq, CSI_B);
                end
                seq = put(seq, cursor_final(key));
            end
            [KEY_INS:KEY_PGDN], [KEY_F5:KEY_F12]: begin
                seq = put(seq, ESC_B);
                seq = put(seq, CSI_B);
                seq = put_dec(seq, tilde_num(key));
                if (mod_num != 5'd0) begin
                    seq = put(seq, SEMI_B);
                    seq = put_dec(seq, mod_num);
                end
                seq = put(seq, TILDE_B);
            end
            KEY_RETURN: begin
                seq = put(seq, 8'h0D);
                if (cfg.newline_mode) begin
                    seq = put(seq, 8'h0A);
                end
            end
            KEY_BKSP: begin
                if (esc_prefix) begin
                    seq = put(seq, ESC_B);
                end
                seq = put(seq, (cfg.backspace_sends_del ^ ctrl) ? DEL_B : BS_B);
            end
            KEY_TAB: begin
                seq = put(seq, 8'h09);
            end
            KEY_SHIFT_TAB: begin
                seq = put(seq, ESC_B);
                seq = put(seq, CSI_B);
                seq = put(seq, 8'h5A);
            end
            KEY_ESC: begin
                seq = put(seq, ESC_B);
            end
            KEY_MODIFIER: begin
                seq = '0;
            end
            default: begin
                if (ctrl && key >= KEY_A && key <= KEY_Z) begin
                    if (esc_prefix) begin
                        seq = put(seq, ESC_B);
                    end
                    seq = put(seq, {2'b00, key} - 8'd28);
                end else if (ctrl && key >= KEY_P_SPACE) begin
                    seq = put(seq, ctrl_punct(key));
                end else if (s_tuser) begin
                    if (esc_prefix) begin
                        seq = put(seq, ESC_B);
                    end
                    if (cp < 21'h000080) begin
                        seq = put(seq, {1'b0, cp[6:0]});
                    end else if (cp < 21'h000800) begin
                        seq = put(seq, {3'b110, cp[10:6]});
                        seq = put(seq, {2'b10, cp[5:0]});
                    end else if (cp < 21'h010000) begin
                        seq = put(seq, {4'b1110, cp[15:12]});
                        seq = put(seq, {2'b10, cp[11:6]});
                        seq = put(seq, {2'b10, cp[5:0]});
                    end else begin
                        seq = put(seq, {5'b11110, cp[20:18]});
                        seq = put(seq, {2'b10, cp[17:12]});
                        seq = put(seq, {2'b10, cp[11:6]});
                        seq = put(seq, {2'b10, cp[5:0]});
                    end
                end
            end
        endcase
        if (dropped) begin
            seq = '0;
        end
    end

    // empty sequences are accepted and never queued
    assign s_tready      = ~queue_full;
    assign push_out.seq  = seq;
    assign push_out.push = s_tvalid & ~queue_full & (seq.len != 4'd0);

endmodule

### rtl/tkse_queue.sv
module tkse_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  tkse_pkg::push_t push_in,
    output logic            full,
    output logic            not_empty,
    output tkse_pkg::seq_t  head,
    input  logic            pop
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tkse_pkg::seq_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_in.push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_in.push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push_in.push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_in.push) begin
            mem_reg[wr_ptr_reg] <= push_in.seq;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push_in.push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH)) else $error("queue count past depth");
`endif

endmodule

### rtl/tkse_back.sv
module tkse_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           not_empty,
    input  tkse_pkg::seq_t head,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast
);

    logic [2:0] pos_reg;
    logic [2:0] pos_next;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;
    logic       out_load;
    logic       take;
    logic       is_last;

    always_comb begin
        out_load = ~m_tvalid_reg | m_tready;
        take     = out_load & not_empty;
        is_last  = ({1'b0, pos_reg} + 4'd1) == head.len;
        pop      = take & is_last;
        pos_next = pos_reg;
        if (take) begin
            pos_next = is_last ? 3'd0 : pos_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            if (out_load) begin
                m_tvalid_reg <= not_empty;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_tdata_reg <= head.bytes[pos_reg];
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef NO_ASSERTIONS
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        not_empty |-> ({1'b0, pos_reg} < head.len)) else $error("byte index past sequence");
    a_pop_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (m_tvalid_reg && m_tlast_reg)) else $error("pop without last byte out");
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        not_empty |-> (head.len != 4'd0 && head.len <= 4'd8)) else $error("bad queued length");
`endif

endmodule

### rtl/terminal_key_sequence_encoder.sv
// terminal key sequence encoder
// input channel s_*: one key press per transaction, output channel m_*: one byte
// per transaction with m_tlast on the final byte of each key's sequence
// a key press that maps to no bytes is taken and produces no output transaction
// the front end accepts a press and builds its whole byte sequence in the same
// cycle, a short queue of QUEUE_DEPTH sequences holds them, the back end
// shifts out one byte per cycle from the queue head into the output register
// while the receiver does not stall; the first byte of a press is written into the
// queue and then loaded into the output register; a press yields 1 to 8 bytes, and
// presses keep being accepted while the queue has room
// when the receiver stalls the output register holds, the queue fills, then
// s_tready falls until the last byte of the oldest sequence enters the output register
// configuration writes take effect on the next press and should come only
// while the block is idle
// reset (aresetn low, synchronous) clears the queue, the output valid flag and
// all configuration bits to zero
module terminal_key_sequence_encoder #(
    parameter int unsigned QUEUE_DEPTH = 2  // 2 or more
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [tkse_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic                              cfg_wdata,
    // key press input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,  // key_class[5:0], modifier_mask[9:6], text_code_point[30:10], zero[31]
    input  logic                              s_tuser,  // has_text
    // byte output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,  // out_byte
    output logic                              m_tlast   // last_byte
);

    tkse_pkg::cfg_t  cfg_reg;
    tkse_pkg::push_t push;
    tkse_pkg::seq_t  head;
    logic            queue_full;
    logic            queue_not_empty;
    logic            pop;

    // register writes, indexes outside the list are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                tkse_pkg::REG_APP_CURSOR:   cfg_reg.app_cursor_mode     <= cfg_wdata;
                tkse_pkg::REG_NEWLINE:      cfg_reg.newline_mode        <= cfg_wdata;
                tkse_pkg::REG_ALT_IS_META:  cfg_reg.alt_is_meta         <= cfg_wdata;
                tkse_pkg::REG_BKSP_DEL:     cfg_reg.backspace_sends_del <= cfg_wdata;
                tkse_pkg::REG_META_RESERVE: cfg_reg.meta_alone_reserved <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // classify the press and build its byte sequence
    tkse_front u_front (
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push_out   (push)
    );

    // decouples press acceptance from byte output
    tkse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_in   (push),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head),
        .pop       (pop)
    );

    // one byte per output transaction
    tkse_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .not_empty (queue_not_empty),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
